>>> rtl/ttcp_pkg.sv
package ttcp_pkg;

  localparam int MAT_ENTRIES = 12;
  localparam int XF_LAT      = 2;
  localparam int DIV_BITS    = 18;
  localparam int CULL_STG    = XF_LAT + 6;
  localparam int OUT_LAT     = XF_LAT + DIV_BITS + 3;
  localparam int SW          = DIV_BITS + 3;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic FUNC_MATRIX = 1'b0;
  localparam logic FUNC_TRI    = 1'b1;

  localparam logic signed [65:0]   S32_MAX = 66'sh7FFF_FFFF;
  localparam logic signed [65:0]   S32_MIN = -66'sh8000_0000;
  localparam logic signed [SW-1:0] S16_MAX = SW'(32767);
  localparam logic signed [SW-1:0] S16_MIN = -SW'(32768);

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_FOCAL    = 2'd2
  } reg_idx_t;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [15:0] scr_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [30:0]        focal;
  } cfg_t;

  function automatic q16_t sat32(input logic signed [65:0] v);
    q16_t r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic scr_t sat16(input logic signed [SW-1:0] v);
    scr_t r;
    if (v > S16_MAX) r = 16'sh7FFF;
    else if (v < S16_MIN) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

>>> rtl/ttcp_if.sv
interface ttcp_in_if;
  import ttcp_pkg::*;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  entry_index;
  q16_t        entry_value;
  q16_t        ax;
  q16_t        ay;
  q16_t        az;
  q16_t        bx;
  q16_t        by_coord;
  q16_t        bz;
  q16_t        cx_coord;
  q16_t        cy_coord;
  q16_t        cz_coord;
  modport source (output valid, func, entry_index, entry_value, ax, ay, az, bx, by_coord,
                  bz, cx_coord, cy_coord, cz_coord, input ready);
  modport sink (input valid, func, entry_index, entry_value, ax, ay, az, bx, by_coord,
                bz, cx_coord, cy_coord, cz_coord, output ready);
endinterface

interface ttcp_out_if;
  import ttcp_pkg::*;
  logic valid;
  logic ready;
  scr_t screen_ax;
  scr_t screen_ay;
  scr_t screen_bx;
  scr_t screen_by;
  scr_t screen_cx;
  scr_t screen_cy;
  q16_t depth_a;
  q16_t depth_b;
  q16_t depth_c;
  modport source (output valid, screen_ax, screen_ay, screen_bx, screen_by, screen_cx,
                  screen_cy, depth_a, depth_b, depth_c, input ready);
  modport sink (input valid, screen_ax, screen_ay, screen_bx, screen_by, screen_cx,
                screen_cy, depth_a, depth_b, depth_c, output ready);
endinterface

>>> rtl/ttcp_lane.sv
module ttcp_lane (
  input  logic                                     clk,
  input  logic                                     ce,
  input  ttcp_pkg::vec_t                           v_in,
  input  logic [ttcp_pkg::MAT_ENTRIES-1:0][31:0]   mat,
  input  ttcp_pkg::cfg_t                           cfg,
  output ttcp_pkg::vec_t                           t_out,
  output ttcp_pkg::scr_t                           sx,
  output ttcp_pkg::scr_t                           sy,
  output ttcp_pkg::q16_t                           depth
);
  import ttcp_pkg::*;

  localparam int DW = 48 + DIV_BITS;

  typedef struct packed {
    logic [62:0]         rem;
    logic [47:0]         den;
    logic [DIV_BITS-1:0] q;
    logic                neg;
    logic                zero;
    logic                sat;
  } div_t;

  q16_t               vc [3];
  logic signed [63:0] prod_r [3][3];
  q16_t               trans_r [3];
  logic signed [65:0] tot_c [3];
  vec_t               t_r;
  logic signed [63:0] num_r [2];
  q16_t               z3_r;
  div_t               pre_c [2];
  div_t               div_r [DIV_BITS+1][2];
  div_t               div_nxt [DIV_BITS][2];
  q16_t               dz_r [DIV_BITS+1];
  logic [DIV_BITS:0]  mag_c [2];
  logic signed [SW-1:0] q_c [2];
  scr_t               sx_r;
  scr_t               sy_r;
  q16_t               depth_r;

  assign vc[0] = v_in.x;
  assign vc[1] = v_in.y;
  assign vc[2] = v_in.z;

  // affine transform: products, then sum with floor shift and translation
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= vc[r] * $signed(mat[r*3+c]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        trans_r[c] <= $signed(mat[9+c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot_c[c] = ((66'(prod_r[0][c]) + 66'(prod_r[1][c]) + 66'(prod_r[2][c])) >>> 16)
                 + 66'(trans_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t_r.x <= sat32(tot_c[0]);
      t_r.y <= sat32(tot_c[1]);
      t_r.z <= sat32(tot_c[2]);
    end
  end

  assign t_out = t_r;

  // projection numerators
  always_ff @(posedge clk) begin
    if (ce) begin
      num_r[0] <= t_r.x * $signed({1'b0, cfg.focal});
      num_r[1] <= t_r.y * $signed({1'b0, cfg.focal});
      z3_r     <= t_r.z;
    end
  end

  // divider setup: magnitudes, sign and overflow check
  always_comb begin
    logic [63:0] abs_num;
    logic [31:0] abs_z;
    abs_num = '0;
    abs_z   = z3_r[31] ? 32'(-z3_r) : 32'(z3_r);
    for (int j = 0; j < 2; j++) begin
      abs_num       = num_r[j][63] ? 64'(-num_r[j]) : 64'(num_r[j]);
      pre_c[j].rem  = abs_num[62:0];
      pre_c[j].den  = {abs_z, 16'h0000};
      pre_c[j].q    = '0;
      pre_c[j].neg  = num_r[j][63] ^ z3_r[31];
      pre_c[j].zero = (num_r[j] == 64'sd0);
      pre_c[j].sat  = DW'(abs_num[62:0]) >= {abs_z, 16'h0000, {DIV_BITS{1'b0}}};
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    always_comb begin
      logic [DW-1:0] trial;
      logic          ge;
      trial = '0;
      ge    = 1'b0;
      for (int j = 0; j < 2; j++) begin
        div_nxt[k][j] = div_r[k][j];
        trial = DW'(div_r[k][j].den) << B;
        ge    = DW'(div_r[k][j].rem) >= trial;
        if (ge) begin
          div_nxt[k][j].rem = 63'(DW'(div_r[k][j].rem) - trial);
        end
        div_nxt[k][j].q[B] = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      div_r[0] <= pre_c;
      dz_r[0]  <= z3_r;
      for (int k = 0; k < DIV_BITS; k++) begin
        div_r[k+1] <= div_nxt[k];
        dz_r[k+1]  <= dz_r[k];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      mag_c[j] = div_r[DIV_BITS][j].sat ? {1'b1, {DIV_BITS{1'b0}}}
                                         : {1'b0, div_r[DIV_BITS][j].q};
      if (div_r[DIV_BITS][j].zero) q_c[j] = '0;
      else if (div_r[DIV_BITS][j].neg) q_c[j] = -$signed(SW'(mag_c[j]));
      else q_c[j] = $signed(SW'(mag_c[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sx_r    <= sat16(SW'(cfg.cx) - q_c[0]);
      sy_r    <= sat16(SW'(cfg.cy) + q_c[1]);
      depth_r <= dz_r[DIV_BITS];
    end
  end

  assign sx    = sx_r;
  assign sy    = sy_r;
  assign depth = depth_r;

endmodule

>>> rtl/ttcp_cull.sv
module ttcp_cull (
  input  logic           clk,
  input  logic           ce,
  input  ttcp_pkg::vec_t ta,
  input  ttcp_pkg::vec_t tb,
  input  ttcp_pkg::vec_t tc,
  output logic           vis
);
  import ttcp_pkg::*;

  logic signed [32:0]  d1_r [3];
  logic signed [32:0]  d2_r [3];
  logic signed [33:0]  s1_r [3];
  logic signed [33:0]  s2_r [3];
  logic signed [33:0]  s3_r [3];
  logic signed [65:0]  pa_r [3];
  logic signed [65:0]  pb_r [3];
  logic signed [66:0]  n_r [3];
  logic signed [66:0]  lo_r [3];
  logic signed [68:0]  hi_r [3];
  logic signed [68:0]  lsum_r;
  logic signed [70:0]  hsum_r;
  logic signed [103:0] dot_c;
  logic                vis_r;

  q16_t a [3];
  q16_t b [3];
  q16_t c [3];

  assign a = '{ta.x, ta.y, ta.z};
  assign b = '{tb.x, tb.y, tb.z};
  assign c = '{tc.x, tc.y, tc.z};

  assign dot_c = (104'(hsum_r) <<< 32) + 104'(lsum_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= 33'(b[k]) - 33'(a[k]);
        d2_r[k] <= 33'(c[k]) - 33'(a[k]);
        s1_r[k] <= 34'(a[k]) + 34'(b[k]) + 34'(c[k]);
      end
      // edge cross product terms
      pa_r[0] <= d1_r[1] * d2_r[2];
      pb_r[0] <= d1_r[2] * d2_r[1];
      pa_r[1] <= d1_r[2] * d2_r[0];
      pb_r[1] <= d1_r[0] * d2_r[2];
      pa_r[2] <= d1_r[0] * d2_r[1];
      pb_r[2] <= d1_r[1] * d2_r[0];
      s2_r    <= s1_r;
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= 67'(pa_r[k]) - 67'(pb_r[k]);
      end
      s3_r <= s2_r;
      // centroid dot normal, normal split into high and low words
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= s3_r[k] * $signed({1'b0, n_r[k][31:0]});
        hi_r[k] <= s3_r[k] * $signed(n_r[k][66:32]);
      end
      lsum_r <= 69'(lo_r[0]) + 69'(lo_r[1]) + 69'(lo_r[2]);
      hsum_r <= 71'(hi_r[0]) + 71'(hi_r[1]) + 71'(hi_r[2]);
      vis_r  <= !dot_c[103] && (dot_c != 104'sd0);
    end
  end

  assign vis = vis_r;

endmodule

>>> rtl/triangle_transform_cull_project_unit.sv
// Triangle transform, back-face cull and perspective projection. One request per clock is
// taken while the output is not stalled; a matrix-entry write takes effect for every
// triangle taken after it. A triangle's result passes through two transform stages, the
// projection multiply, the divider setup, the 18-stage restoring divider and the output
// register, in each of the three vertex lanes; a culled triangle gives no result. A stalled
// result holds the whole pipeline, and input is taken again as soon as the result register
// is free or being read.
module triangle_transform_cull_project_unit (
  input  logic        clk,
  input  logic        rst_n,
  ttcp_in_if.sink     in_ch,
  ttcp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ttcp_pkg::*;

  logic [MAT_ENTRIES-1:0][31:0] mat_r;
  cfg_t                         cfg_r;
  logic [OUT_LAT:1]             vld_r;
  logic                         ce;
  logic                         in_acc;
  logic                         tri_acc;
  logic                         vis;
  logic                         cfg_wr;
  reg_idx_t                     ridx;
  vec_t                         v_in [3];
  vec_t                         t_v [3];
  scr_t                         sx [3];
  scr_t                         sy [3];
  q16_t                         dz [3];

  assign ce      = !vld_r[OUT_LAT] || out_ch.ready;
  assign in_acc  = in_ch.valid && ce;
  assign tri_acc = in_acc && (in_ch.func == FUNC_TRI);
  assign in_ch.ready = ce;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cx    <= '0;
      cfg_r.cy    <= '0;
      cfg_r.focal <= 31'(ONE_Q16);
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_CENTER_X: cfg_r.cx    <= pwdata[15:0];
        REG_CENTER_Y: cfg_r.cy    <= pwdata[15:0];
        REG_FOCAL:    cfg_r.focal <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CENTER_X: prdata = 32'(cfg_r.cx);
      REG_CENTER_Y: prdata = 32'(cfg_r.cy);
      REG_FOCAL:    prdata = {1'b0, cfg_r.focal};
      default:      prdata = '0;
    endcase
  end

  // matrix, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAT_ENTRIES; k++) begin
        mat_r[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q16 : 32'h0000_0000;
      end
    end else if (in_acc && (in_ch.func == FUNC_MATRIX)
                 && (in_ch.entry_index < 4'(MAT_ENTRIES))) begin
      mat_r[in_ch.entry_index] <= in_ch.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r[1] <= tri_acc;
      for (int k = 2; k <= OUT_LAT; k++) begin
        vld_r[k] <= (k == CULL_STG + 1) ? (vld_r[k-1] && vis) : vld_r[k-1];
      end
    end
  end

  assign v_in[0] = '{in_ch.ax, in_ch.ay, in_ch.az};
  assign v_in[1] = '{in_ch.bx, in_ch.by_coord, in_ch.bz};
  assign v_in[2] = '{in_ch.cx_coord, in_ch.cy_coord, in_ch.cz_coord};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ttcp_lane u_lane (
      .clk   (clk),
      .ce    (ce),
      .v_in  (v_in[i]),
      .mat   (mat_r),
      .cfg   (cfg_r),
      .t_out (t_v[i]),
      .sx    (sx[i]),
      .sy    (sy[i]),
      .depth (dz[i])
    );
  end

  ttcp_cull u_cull (
    .clk (clk),
    .ce  (ce),
    .ta  (t_v[0]),
    .tb  (t_v[1]),
    .tc  (t_v[2]),
    .vis (vis)
  );

  assign out_ch.valid     = vld_r[OUT_LAT];
  assign out_ch.screen_ax = sx[0];
  assign out_ch.screen_ay = sy[0];
  assign out_ch.screen_bx = sx[1];
  assign out_ch.screen_by = sy[1];
  assign out_ch.screen_cx = sx[2];
  assign out_ch.screen_cy = sy[2];
  assign out_ch.depth_a   = dz[0];
  assign out_ch.depth_b   = dz[1];
  assign out_ch.depth_c   = dz[2];

  a_mat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.func == FUNC_MATRIX)) |=> !vld_r[1])
    else $error("matrix write entered the triangle pipeline");

  a_cull_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ce && vld_r[CULL_STG] && !vis) |=> !vld_r[CULL_STG+1])
    else $error("back-facing triangle not dropped");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!ce) |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule
